/* rtl/core/agd_pkg.sv */
// agd_pkg: event codes, force levels and register indexes of the gesture detector
// used by accel_gesture_detector, no dependencies
package agd_pkg;

  localparam int unsigned AxisW  = 16;
  localparam int unsigned ForceW = 32;
  localparam int unsigned CodeW  = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned MaxEvents = 5;

  // event codes
  localparam logic [CodeW-1:0] EV_NONE      = 4'd0;
  localparam logic [CodeW-1:0] EV_TILT_UP   = 4'd1;
  localparam logic [CodeW-1:0] EV_TILT_DOWN = 4'd2;
  localparam logic [CodeW-1:0] EV_LEFT      = 4'd3;
  localparam logic [CodeW-1:0] EV_RIGHT     = 4'd4;
  localparam logic [CodeW-1:0] EV_FACE_UP   = 4'd5;
  localparam logic [CodeW-1:0] EV_FACE_DOWN = 4'd6;
  localparam logic [CodeW-1:0] EV_FREEFALL  = 4'd7;
  localparam logic [CodeW-1:0] EV_3G        = 4'd8;
  localparam logic [CodeW-1:0] EV_6G        = 4'd9;
  localparam logic [CodeW-1:0] EV_8G        = 4'd10;
  localparam logic [CodeW-1:0] EV_SHAKE     = 4'd11;
  localparam logic [CodeW-1:0] EV_2G        = 4'd12;

  // squared force levels, 1024 per g, lowest level first
  localparam logic [3:0][ForceW-1:0] G_LEVELS = {32'd67108864, 32'd37748736,
                                                 32'd9437184, 32'd4194304};
  localparam logic [3:0][CodeW-1:0]  G_CODES  = {EV_8G, EV_6G, EV_3G, EV_2G};

  localparam logic signed [AxisW:0] NOMINAL_G = 17'sd1000;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_SHAKE_TOL   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_TILT_TOL    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_FREEFALL    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SHAKE_CNT   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SHAKE_DECAY = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SHAKE_REARM = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_GEST_HOLD   = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_IMP_HOLD    = 3'd7;

endpackage

/* rtl/core/accel_gesture_detector.sv */
// accel_gesture_detector: shake, g-impulse and posture events from accelerometer samples
// depends on agd_pkg
//
//  channel   | dir | handshake              | payload
//  s_axis    | in  | tvalid/tready          | tdata: accel_x, accel_y, accel_z
//  m_axis    | out | tvalid/tready, tlast   | tdata: event_code; tlast: last_of_sample
//  cfg       | in  | cfg_we_i, no back-pressure | cfg_idx_i, cfg_data_i
//
// a sample passes an input register, a squaring register (three 16x16 multipliers)
// and an event stage that updates all state and loads the result shift register.
// one sample per cycle while each makes at most one event and m_axis does not stall; a
// sample with several events holds the single output port until all of them are sent.
// reset clears all tracking state and loads the register defaults; stalls on m_axis
// back up through the pipeline to s_axis_tready.
module accel_gesture_detector
  import agd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [47:0]         s_axis_tdata,   // accel_x, accel_y, accel_z
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,   // event_code, zero padding
  output logic                m_axis_tlast,   // last_of_sample
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // configuration
  logic [14:0] shake_tol_q;
  logic [9:0]  tilt_tol_q;
  logic [31:0] freefall_q;
  logic [3:0]  shake_cnt_q;
  logic [7:0]  shake_decay_q;
  logic [7:0]  shake_rearm_q;
  logic [3:0]  gest_hold_q;
  logic [3:0]  imp_hold_q;

  // pipeline
  logic                    s1_valid_q, s2_valid_q;
  logic signed [AxisW-1:0] s1_x_q, s1_y_q, s1_z_q;
  logic signed [AxisW-1:0] s2_x_q, s2_y_q, s2_z_q;
  logic [30:0]             sq_x_q, sq_y_q, sq_z_q;
  logic [AxisW-1:0]        abs_x, abs_y, abs_z;
  logic                    s1_ready, s2_ready, proc, bundle_free, out_xfer;

  // detector state
  logic [3:0] mask_q, mask_d;
  logic [3:0] imp_q, imp_d;
  logic [2:0] dir_q, dir_d;
  logic       fired_q, fired_d;
  logic [3:0] cross_q, cross_d;
  logic [7:0] timer_q, timer_d;
  logic [3:0] cand_q, cand_d;
  logic [3:0] stable_q, stable_d;
  logic [3:0] rep_q, rep_d;

  // result shift register
  logic [CodeW-1:0] out_code_q [MaxEvents];
  logic [CodeW-1:0] out_code_d [MaxEvents];
  logic [2:0]       out_cnt_q, out_cnt_d;
  logic [CodeW-1:0] ev_codes [MaxEvents];
  logic [2:0]       ev_n;

  // event stage signals
  logic [ForceW-1:0]       force_w;
  logic [3:0]              g_hit;
  logic [2:0]              flip;
  logic signed [AxisW:0]   tol_s, lo_s, hi_s, ax_s, ay_s, az_s;
  logic [CodeW-1:0]        cls;
  logic                    shake_ev;

  assign out_xfer    = m_axis_tvalid && m_axis_tready;
  assign bundle_free = (out_cnt_q == 3'd0) || (out_cnt_q == 3'd1 && m_axis_tready);
  assign proc        = s2_valid_q && bundle_free;
  assign s2_ready    = !s2_valid_q || proc;
  assign s1_ready    = !s1_valid_q || s2_ready;
  assign s_axis_tready = s1_ready;

  assign m_axis_tvalid = (out_cnt_q != 3'd0);
  assign m_axis_tdata  = {4'b0000, out_code_q[0]};
  assign m_axis_tlast  = (out_cnt_q == 3'd1);

  assign abs_x = s1_x_q[AxisW-1] ? (~s1_x_q + 16'd1) : s1_x_q;
  assign abs_y = s1_y_q[AxisW-1] ? (~s1_y_q + 16'd1) : s1_y_q;
  assign abs_z = s1_z_q[AxisW-1] ? (~s1_z_q + 16'd1) : s1_z_q;

  // event stage: all per-sample state updates
  always_comb begin
    mask_d   = mask_q;
    imp_d    = imp_q;
    dir_d    = dir_q;
    fired_d  = fired_q;
    cross_d  = cross_q;
    timer_d  = timer_q;
    cand_d   = cand_q;
    stable_d = stable_q;
    rep_d    = rep_q;
    shake_ev = 1'b0;
    cls      = EV_NONE;
    ev_n     = 3'd0;
    for (int k = 0; k < MaxEvents; k++) ev_codes[k] = EV_NONE;

    force_w = {1'b0, sq_x_q} + {1'b0, sq_y_q} + {1'b0, sq_z_q};

    // g impulse levels
    for (int i = 0; i < 4; i++) g_hit[i] = (force_w > G_LEVELS[i]) && !mask_q[i];
    if (force_w > G_LEVELS[0]) begin
      imp_d  = 4'd0;
      mask_d = mask_q | g_hit;
    end
    for (int i = 0; i < 4; i++) begin
      if (g_hit[i]) begin
        ev_codes[ev_n] = G_CODES[i];
        ev_n = ev_n + 3'd1;
      end
    end
    if (imp_d < imp_hold_q) imp_d = imp_d + 4'd1;
    else mask_d = 4'd0;

    // per-axis sign flips
    tol_s = $signed({2'b00, shake_tol_q});
    ax_s  = {s2_x_q[AxisW-1], s2_x_q};
    ay_s  = {s2_y_q[AxisW-1], s2_y_q};
    az_s  = {s2_z_q[AxisW-1], s2_z_q};
    flip[0] = (ax_s < -tol_s && dir_q[0]) || (ax_s > tol_s && !dir_q[0]);
    flip[1] = (ay_s < -tol_s && dir_q[1]) || (ay_s > tol_s && !dir_q[1]);
    flip[2] = (az_s < -tol_s && dir_q[2]) || (az_s > tol_s && !dir_q[2]);
    dir_d   = dir_q ^ flip;

    if ((flip != 3'b000) && (cross_q < shake_cnt_q)) begin
      cross_d = cross_q + 4'd1;
      if (cross_d == 4'd1) timer_d = 8'd0;
      if (cross_d == shake_cnt_q) begin
        fired_d  = 1'b1;
        timer_d  = 8'd0;
        shake_ev = 1'b1;
      end
    end

    if (!shake_ev) begin
      // crossing decay and re-arm
      if (cross_d != 4'd0) begin
        timer_d = timer_d + 8'd1;
        if (fired_d && timer_d >= shake_rearm_q) begin
          fired_d = 1'b0;
          timer_d = 8'd0;
          cross_d = 4'd0;
        end else if (!fired_d && timer_d >= shake_decay_q) begin
          timer_d = 8'd0;
          cross_d = cross_d - 4'd1;
        end
      end

      lo_s = $signed({7'b0, tilt_tol_q}) - NOMINAL_G;
      hi_s = NOMINAL_G - $signed({7'b0, tilt_tol_q});
      if (force_w < freefall_q) cls = EV_FREEFALL;
      else if (ax_s < lo_s)     cls = EV_LEFT;
      else if (ax_s > hi_s)     cls = EV_RIGHT;
      else if (ay_s < lo_s)     cls = EV_TILT_DOWN;
      else if (ay_s > hi_s)     cls = EV_TILT_UP;
      else if (az_s < lo_s)     cls = EV_FACE_UP;
      else if (az_s > hi_s)     cls = EV_FACE_DOWN;
      else                      cls = EV_NONE;

      // posture debounce
      if (cls == cand_q) begin
        if (stable_q < gest_hold_q) stable_d = stable_q + 4'd1;
      end else begin
        cand_d   = cls;
        stable_d = 4'd0;
      end
      if (cand_d != rep_q && stable_d >= gest_hold_q) begin
        rep_d = cand_d;
        if (cand_d != EV_NONE) begin
          ev_codes[ev_n] = cand_d;
          ev_n = ev_n + 3'd1;
        end
      end
    end else begin
      lo_s = '0;
      hi_s = '0;
      ev_codes[ev_n] = EV_SHAKE;
      ev_n = ev_n + 3'd1;
    end
  end

  // result shift register
  always_comb begin
    out_cnt_d = out_cnt_q;
    for (int k = 0; k < MaxEvents; k++) out_code_d[k] = out_code_q[k];
    if (out_xfer) begin
      for (int k = 0; k < MaxEvents - 1; k++) out_code_d[k] = out_code_q[k+1];
      out_code_d[MaxEvents-1] = EV_NONE;
      out_cnt_d = out_cnt_q - 3'd1;
    end
    if (proc) begin
      for (int k = 0; k < MaxEvents; k++) out_code_d[k] = ev_codes[k];
      out_cnt_d = ev_n;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shake_tol_q   <= 15'd400;
      tilt_tol_q    <= 10'd200;
      freefall_q    <= 32'd160000;
      shake_cnt_q   <= 4'd4;
      shake_decay_q <= 8'd10;
      shake_rearm_q <= 8'd30;
      gest_hold_q   <= 4'd5;
      imp_hold_q    <= 4'd5;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SHAKE_TOL:   shake_tol_q   <= cfg_data_i[14:0];
        REG_TILT_TOL:    tilt_tol_q    <= cfg_data_i[9:0];
        REG_FREEFALL:    freefall_q    <= cfg_data_i;
        REG_SHAKE_CNT:   shake_cnt_q   <= cfg_data_i[3:0];
        REG_SHAKE_DECAY: shake_decay_q <= cfg_data_i[7:0];
        REG_SHAKE_REARM: shake_rearm_q <= cfg_data_i[7:0];
        REG_GEST_HOLD:   gest_hold_q   <= cfg_data_i[3:0];
        REG_IMP_HOLD:    imp_hold_q    <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      out_cnt_q  <= 3'd0;
      mask_q     <= 4'd0;
      imp_q      <= 4'd0;
      dir_q      <= 3'd0;
      fired_q    <= 1'b0;
      cross_q    <= 4'd0;
      timer_q    <= 8'd0;
      cand_q     <= 4'd0;
      stable_q   <= 4'd0;
      rep_q      <= 4'd0;
    end else begin
      if (s1_ready) s1_valid_q <= s_axis_tvalid;
      if (s2_ready) s2_valid_q <= s1_valid_q;
      out_cnt_q <= out_cnt_d;
      if (proc) begin
        mask_q   <= mask_d;
        imp_q    <= imp_d;
        dir_q    <= dir_d;
        fired_q  <= fired_d;
        cross_q  <= cross_d;
        timer_q  <= timer_d;
        cand_q   <= cand_d;
        stable_q <= stable_d;
        rep_q    <= rep_d;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (s1_ready && s_axis_tvalid) begin
      s1_x_q <= s_axis_tdata[15:0];
      s1_y_q <= s_axis_tdata[31:16];
      s1_z_q <= s_axis_tdata[47:32];
    end
    if (s2_ready && s1_valid_q) begin
      s2_x_q <= s1_x_q;
      s2_y_q <= s1_y_q;
      s2_z_q <= s1_z_q;
      // full-width product, the square of 32768 still fits in 31 bits
      sq_x_q <= 31'({16'd0, abs_x} * {16'd0, abs_x});
      sq_y_q <= 31'({16'd0, abs_y} * {16'd0, abs_y});
      sq_z_q <= 31'({16'd0, abs_z} * {16'd0, abs_z});
    end
    for (int k = 0; k < MaxEvents; k++) out_code_q[k] <= out_code_d[k];
  end

endmodule
